// ===== rtl/hcbd_pkg.sv =====
// Package for the chunked body deframer: byte class record, phase and
// result kind codes, queue depth. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hcbd_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [2:0] {
		PH_DIGITS  = 3'd0,
		PH_SPACES  = 3'd1,
		PH_LINE_LF = 3'd2,
		PH_DATA    = 3'd3,
		PH_TAIL_CR = 3'd4,
		PH_TAIL_LF = 3'd5,
		PH_STOP    = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		K_FRAMING  = 3'd0,
		K_PAYLOAD  = 3'd1,
		K_DONE     = 3'd2,
		K_BAD_END  = 3'd3,
		K_BAD_LINE = 3'd4,
		K_IGNORED  = 3'd5
	} kind_t;

	// one classified input byte
	typedef struct packed {
		logic [7:0] raw;
		logic       is_hex;
		logic [3:0] hex_val;
		logic       is_space;
		logic       is_cr;
		logic       is_lf;
	} byte_class_t;

	// handshake between queue and its neighbors
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage
`default_nettype wire

// ===== rtl/hcbd_front.sv =====
// Front end: takes stream bytes, classifies them and registers the class.
// Depends on hcbd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hcbd_front
	import hcbd_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [7:0]    stream_byte,
	input  wire queue_status_t q_status,
	output logic               push,
	output byte_class_t        push_data
);

	logic        valid_s1;
	byte_class_t class_s1;
	byte_class_t class_d;
	logic        take;

	always_comb begin
		class_d          = '0;
		class_d.raw      = stream_byte;
		class_d.is_space = (stream_byte == CH_SPACE);
		class_d.is_cr    = (stream_byte == CH_CR);
		class_d.is_lf    = (stream_byte == CH_LF);
		if (stream_byte inside {[8'h30:8'h39]}) begin
			class_d.is_hex  = 1'b1;
			class_d.hex_val = stream_byte[3:0];
		end else if (stream_byte inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
			class_d.is_hex  = 1'b1;
			class_d.hex_val = stream_byte[3:0] + 4'd9;
		end
	end

	assign push      = valid_s1 && !q_status.full;
	assign push_data = class_s1;
	assign in_stall  = valid_s1 && q_status.full;
	assign take      = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			class_s1 <= class_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/hcbd_queue.sv =====
// Short queue of classified bytes between front and back end.
// Depends on hcbd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hcbd_queue
	import hcbd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire byte_class_t push_data,
	input  wire logic        pop,
	output byte_class_t      pop_data,
	output queue_status_t    status
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	byte_class_t      mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign status.full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign status.empty = (cnt_q == '0);
	assign pop_data     = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/hcbd_back.sv =====
// Back end: framing state machine, chunk counter and output register.
// Depends on hcbd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hcbd_back
	import hcbd_pkg::*;
#(
	parameter int SIZE_BITS = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire queue_status_t q_status,
	input  wire byte_class_t   q_data,
	output logic               pop,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [2:0]         kind,
	output logic [7:0]         payload_byte
);

	phase_t               phase_q, phase_d;
	logic [SIZE_BITS-1:0] remaining_q, remaining_d;
	logic [SIZE_BITS-1:0] rem_dec;
	logic                 valid_q;
	kind_t                kind_q, kind_d;
	logic [7:0]           pay_q, pay_d;

	assign pop          = !q_status.empty && (!valid_q || !out_stall);
	assign out_valid    = valid_q;
	assign kind         = kind_q;
	assign payload_byte = pay_q;
	assign rem_dec      = remaining_q - 1'b1;

	always_comb begin
		phase_d     = phase_q;
		remaining_d = remaining_q;
		kind_d      = K_FRAMING;
		pay_d       = '0;
		case (phase_q)
			PH_DIGITS, PH_SPACES: begin
				if (phase_q == PH_DIGITS && q_data.is_hex) begin
					// a set bit in the top nibble would be shifted out
					if (remaining_q[SIZE_BITS-1 -: 4] != 4'd0) begin
						kind_d  = K_BAD_LINE;
						phase_d = PH_STOP;
					end else begin
						remaining_d = {remaining_q[SIZE_BITS-5:0], q_data.hex_val};
					end
				end else if (q_data.is_space) begin
					phase_d = PH_SPACES;
				end else if (q_data.is_cr) begin
					phase_d = PH_LINE_LF;
				end else begin
					kind_d  = K_BAD_LINE;
					phase_d = PH_STOP;
				end
			end
			PH_LINE_LF: begin
				if (!q_data.is_lf) begin
					kind_d  = K_BAD_LINE;
					phase_d = PH_STOP;
				end else if (remaining_q != '0) begin
					phase_d = PH_DATA;
				end else begin
					kind_d  = K_DONE;
					phase_d = PH_STOP;
				end
			end
			PH_DATA: begin
				kind_d      = K_PAYLOAD;
				pay_d       = q_data.raw;
				remaining_d = rem_dec;
				if (rem_dec == '0) begin
					phase_d = PH_TAIL_CR;
				end
			end
			PH_TAIL_CR: begin
				if (q_data.is_cr) begin
					phase_d = PH_TAIL_LF;
				end else begin
					kind_d  = K_BAD_END;
					phase_d = PH_STOP;
				end
			end
			PH_TAIL_LF: begin
				if (q_data.is_lf) begin
					phase_d     = PH_DIGITS;
					remaining_d = '0;
				end else begin
					kind_d  = K_BAD_END;
					phase_d = PH_STOP;
				end
			end
			default: begin
				kind_d  = K_IGNORED;
				phase_d = PH_STOP;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_DIGITS;
			remaining_q <= '0;
			valid_q     <= 1'b0;
		end else begin
			if (pop) begin
				phase_q     <= phase_d;
				remaining_q <= remaining_d;
				valid_q     <= 1'b1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= kind_d;
			pay_q  <= pay_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/http_chunked_body_deframer.sv =====
// HTTP/1.1 chunked body deframer, top level: front end, queue, back end.
// Depends on hcbd_pkg, hcbd_front, hcbd_queue, hcbd_back.
//
// Usage: raw body bytes enter on stream_byte with in_valid/in_stall; each
// accepted beat yields exactly one result beat on out_valid/out_stall,
// carrying kind (0 framing, 1 payload, 2 body complete, 3 bad chunk end,
// 4 bad size line, 5 ignored) and payload_byte (zero unless payload).
// With no stall a beat passes the front register, a queue write and the
// output register in turn. Throughput: one byte per cycle while out_stall
// is low; the framing state machine updates once per byte in the back end.
// Chunk sizes are hex, either case, up to SIZE_BITS bits; an overflowing
// digit is a bad size line. After body complete or any error the block
// stays stopped and marks every later byte ignored until reset.
// Reset (arst_n low) empties the pipeline and returns to size parsing.
// A stall on the result side holds the output register; the two-entry
// queue and front register then fill and in_stall rises, without losing
// or repeating a beat.
`timescale 1ns / 1ps
`default_nettype none
module http_chunked_body_deframer
	import hcbd_pkg::*;
#(
	parameter int SIZE_BITS = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] stream_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [2:0]      kind,
	output logic [7:0]      payload_byte
);

	queue_status_t q_status;
	logic          push;
	logic          pop;
	byte_class_t   push_data;
	byte_class_t   pop_data;

	// classify bytes
	hcbd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.stream_byte (stream_byte),
		.q_status    (q_status),
		.push        (push),
		.push_data   (push_data)
	);

	// decouple front from back
	hcbd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (q_status)
	);

	// framing state machine and result register
	hcbd_back #(
		.SIZE_BITS (SIZE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_status     (q_status),
		.q_data       (pop_data),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.payload_byte (payload_byte)
	);

endmodule
`default_nettype wire

// ===== rtl/hcbd_checker.sv =====
// Port-level checker for the deframer and its bind to the top level.
// Depends on hcbd_pkg and http_chunked_body_deframer.
`timescale 1ns / 1ps
`default_nettype none
module hcbd_checker
	import hcbd_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic [7:0] stream_byte,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [2:0] kind,
	input wire logic [7:0] payload_byte
);

	logic stopped_q;
	logic terminal;

	assign terminal = (kind == K_DONE) || (kind == K_BAD_END) || (kind == K_BAD_LINE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stopped_q <= 1'b0;
		end else if (out_valid && !out_stall && terminal) begin
			stopped_q <= 1'b1;
		end
	end

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(stream_byte))
		else $error("input beat changed while stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(payload_byte))
		else $error("result beat changed while stalled");

	a_pay_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind != K_PAYLOAD) |-> payload_byte == 8'd0)
		else $error("payload byte nonzero on a non-payload beat");

	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stopped_q |-> kind == K_IGNORED)
		else $error("result after end or error is not ignored");

	a_ignored_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == K_IGNORED) |-> stopped_q)
		else $error("ignored beat before any end or error");

endmodule

bind http_chunked_body_deframer hcbd_checker u_hcbd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.stream_byte  (stream_byte),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.kind         (kind),
	.payload_byte (payload_byte)
);
`default_nettype wire
